### sv/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types and constants of the huffman stream decoder: item kinds,
// error codes, result record and the controller states.
// ----------------------------------------------------------------------------
package hsd_pkg;

  // default storage sizes
  localparam int unsigned HsdNodeSlots  = 512;
  localparam int unsigned HsdStackSlots = 256;

  localparam int unsigned SymW   = 8;
  localparam int unsigned CountW = 32;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_INTERNAL = 2'd0,
    KIND_LEAF     = 2'd1,
    KIND_CODE     = 2'd2
  } kind_e;

  // result error codes
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_NO_TREE = 2'd1,
    ERR_REJECT  = 2'd2
  } err_e;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // one result request
  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last_symbol;
    err_e            error;
  } result_t;

endpackage

### sv/hsd_ram.sv
// ----------------------------------------------------------------------------
// hsd_ram
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered. No reset on the contents.
// ----------------------------------------------------------------------------
module hsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/hsd_out_buffer.sv
// ----------------------------------------------------------------------------
// hsd_out_buffer
// Output register with one skid stage behind it, so that a result can be
// written while the previous one is still stalled at the output.
// ----------------------------------------------------------------------------
module hsd_out_buffer
  import hsd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    pop;

  assign pop = out_valid_q && !out_stall_i;

  // fill and drain
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (pop) begin
      out_valid_d = skid_valid_q;
      out_data_d  = skid_data_q;
      skid_valid_d = 1'b0;
    end
    if (push_i) begin
      if (!out_valid_q || (pop && !skid_valid_q)) begin
        out_valid_d = 1'b1;
        out_data_d  = push_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = push_data_i;
      end
    end
  end

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload flops
  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### sv/huffman_stream_decoder.sv
// ----------------------------------------------------------------------------
// huffman_stream_decoder
// Builds a code tree from preorder tokens into a node RAM and an open-node
// stack RAM, then walks it one code bit per item, emitting decoded symbols.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------
//  in      | in  | in_valid_i/in_stall_o | kind_i, leaf_symbol_i, code_bit_i
//  out     | out | out_valid_o/out_stall_i | symbol_o, last_symbol_o, error_o
//  cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_data_i (expected_symbols)
//
//  An item is accepted in IDLE, whose accept cycle issues the RAM reads; the
//  next cycle (EXEC) uses the registered read data and writes back, and no
//  new item is taken during EXEC. This is set by the registered node RAM read.
//  A parent's right-child pointer is written in the cycle after, forwarded.
//  Reset and a cfg write clear the counters at once; the RAMs are not swept.
//  A stalled output keeps one more result in a skid stage before in stalls.
//
module huffman_stream_decoder
  import hsd_pkg::*;
#(
  parameter int unsigned NODE_SLOTS  = HsdNodeSlots,
  parameter int unsigned STACK_SLOTS = HsdStackSlots
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        kind_i,
  input  logic [SymW-1:0]   leaf_symbol_i,
  input  logic              code_bit_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SymW-1:0]   symbol_o,
  output logic              last_symbol_o,
  output logic [1:0]        error_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  localparam int unsigned NW = $clog2(NODE_SLOTS);
  localparam int unsigned SW = $clog2(STACK_SLOTS);
  localparam int unsigned UW = NW + 1;
  localparam int unsigned DW = SW + 1;
  localparam int unsigned EW = 1 + SymW + NW;
  localparam int unsigned TW = NW + 1;

  state_e state_q, state_d;
  logic   busy;
  logic   in_acc;
  logic   cfg_acc;
  logic   skid_full;

  // latched item
  logic [1:0]      kind_q;
  logic [SymW-1:0] sym_q;
  logic [NW-1:0]   nxt_q;
  logic            fwd_q;

  // tree and walk state
  logic [CountW-1:0] expected_q, expected_d;
  logic [CountW-1:0] done_q, done_d;
  logic [UW-1:0]     used_q, used_d;
  logic [DW-1:0]     depth_q, depth_d;
  logic              complete_q, complete_d;
  logic [NW-1:0]     top_node_q, top_node_d;
  logic              top_right_q, top_right_d;
  logic              root_leaf_q, root_leaf_d;
  logic [SymW-1:0]   root_sym_q, root_sym_d;
  logic [NW-1:0]     root_right_q, root_right_d;
  logic [NW-1:0]     cur_idx_q, cur_idx_d;
  logic [NW-1:0]     cur_right_q, cur_right_d;

  // deferred parent right-pointer write
  logic          pend_valid_q, pend_valid_d;
  logic [NW-1:0] pend_addr_q, pend_addr_d;
  logic [NW-1:0] pend_right_q, pend_right_d;

  // memory ports
  logic          node_we_x;
  logic [NW-1:0] node_waddr_x;
  logic [EW-1:0] node_wdata_x;
  logic          node_we;
  logic [NW-1:0] node_waddr;
  logic [EW-1:0] node_wdata;
  logic [NW-1:0] node_raddr;
  logic [EW-1:0] node_rdata;
  logic [EW-1:0] entry;
  logic          stk_we;
  logic [SW-1:0] stk_waddr;
  logic [TW-1:0] stk_wdata;
  logic [SW-1:0] stk_raddr;
  logic [TW-1:0] stk_rdata;

  // exec datapath terms
  logic          is_leaf;
  logic          store_full;
  logic          attach;
  logic          att_right;
  logic [DW-1:0] depth_after;
  logic          overflow;
  logic          reject;
  logic [NW-1:0] idx;
  logic [CountW-1:0] done_inc;

  logic    res_push;
  result_t res;
  result_t out_data;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    busy = 1'b0;
    case (state_q)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: busy = 1'b1;
      default: busy = 1'b0;
    endcase
    in_stall_o  = busy || skid_full;
    cfg_ready_o = !busy;
  end

  // read addresses issued in the accept cycle
  assign node_raddr = code_bit_i ? cur_right_q : (cur_idx_q + {{(NW-1){1'b0}}, 1'b1});
  assign stk_raddr  = depth_q[SW-1:0] - SW'(2);

  // node word seen by the walk, with the deferred write forwarded
  assign entry = fwd_q ? {1'b0, {SymW{1'b0}}, pend_right_q} : node_rdata;

  // tree token decisions
  assign is_leaf     = (kind_q == KIND_LEAF);
  assign store_full  = (used_q >= UW'(NODE_SLOTS));
  assign attach      = (used_q != '0);
  assign att_right   = attach && top_right_q;
  assign depth_after = depth_q - {{(DW-1){1'b0}}, att_right};
  assign overflow    = !is_leaf && (depth_after >= DW'(STACK_SLOTS));
  assign reject      = complete_q || store_full || overflow;
  assign idx         = used_q[NW-1:0];
  assign done_inc    = done_q + {{(CountW-1){1'b0}}, 1'b1};

  // execute: read data in, state and memory writes out
  always_comb begin
    expected_d   = expected_q;
    done_d       = done_q;
    used_d       = used_q;
    depth_d      = depth_q;
    complete_d   = complete_q;
    top_node_d   = top_node_q;
    top_right_d  = top_right_q;
    root_leaf_d  = root_leaf_q;
    root_sym_d   = root_sym_q;
    root_right_d = root_right_q;
    cur_idx_d    = cur_idx_q;
    cur_right_d  = cur_right_q;
    pend_valid_d = 1'b0;
    pend_addr_d  = pend_addr_q;
    pend_right_d = pend_right_q;
    node_we_x    = 1'b0;
    node_waddr_x = idx;
    node_wdata_x = {is_leaf, (is_leaf ? sym_q : {SymW{1'b0}}), {NW{1'b0}}};
    stk_we       = 1'b0;
    stk_waddr    = depth_after[SW-1:0] - {{(SW-1){1'b0}}, 1'b1};
    stk_wdata    = {top_node_q, 1'b1};
    res_push     = 1'b0;
    res          = '{symbol: '0, last_symbol: 1'b0, error: ERR_NONE};

    if (busy) begin
      case (kind_q)
        KIND_INTERNAL, KIND_LEAF: begin
          if (reject) begin
            res_push  = 1'b1;
            res.error = ERR_REJECT;
          end else begin
            node_we_x = 1'b1;
            used_d    = used_q + {{(UW-1){1'b0}}, 1'b1};
            if (!attach) begin
              // first token is the root
              root_leaf_d = is_leaf;
              root_sym_d  = sym_q;
              if (is_leaf) begin
                complete_d = 1'b1;
              end else begin
                top_node_d  = idx;
                top_right_d = 1'b0;
                depth_d     = {{(DW-1){1'b0}}, 1'b1};
              end
            end else if (att_right) begin
              // right child closes the parent on top
              pend_valid_d = 1'b1;
              pend_addr_d  = top_node_q;
              pend_right_d = idx;
              if (top_node_q == '0) begin
                root_right_d = idx;
                cur_right_d  = idx;
              end
              if (is_leaf) begin
                depth_d     = depth_after;
                top_node_d  = stk_rdata[TW-1:1];
                top_right_d = stk_rdata[0];
                if (depth_after == '0) begin
                  complete_d = 1'b1;
                end
              end else begin
                top_node_d  = idx;
                top_right_d = 1'b0;
              end
            end else begin
              // left child, parent now waits for its right child
              if (is_leaf) begin
                top_right_d = 1'b1;
              end else begin
                stk_we      = 1'b1;
                stk_waddr   = depth_q[SW-1:0] - {{(SW-1){1'b0}}, 1'b1};
                top_node_d  = idx;
                top_right_d = 1'b0;
                depth_d     = depth_q + {{(DW-1){1'b0}}, 1'b1};
              end
            end
          end
        end
        KIND_CODE: begin
          if (!complete_q) begin
            res_push  = 1'b1;
            res.error = ERR_NO_TREE;
          end else if (done_q != expected_q) begin
            if (root_leaf_q) begin
              res_push        = 1'b1;
              res.symbol      = root_sym_q;
              res.last_symbol = (done_inc == expected_q);
              done_d          = done_inc;
            end else if (entry[EW-1]) begin
              res_push        = 1'b1;
              res.symbol      = entry[EW-2:NW];
              res.last_symbol = (done_inc == expected_q);
              done_d          = done_inc;
              cur_idx_d       = '0;
              cur_right_d     = root_right_q;
            end else begin
              cur_idx_d   = nxt_q;
              cur_right_d = entry[NW-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end

    // register write clears the tree and counters
    if (cfg_acc) begin
      expected_d  = cfg_data_i;
      done_d      = '0;
      used_d      = '0;
      depth_d     = '0;
      complete_d  = 1'b0;
      cur_idx_d   = '0;
      top_right_d = 1'b0;
    end
  end

  // node RAM write port: exec write or the deferred right pointer
  always_comb begin
    node_we    = node_we_x || pend_valid_q;
    node_waddr = node_we_x ? node_waddr_x : pend_addr_q;
    node_wdata = node_we_x ? node_wdata_x : {1'b0, {SymW{1'b0}}, pend_right_q};
  end

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      expected_q   <= '0;
      done_q       <= '0;
      used_q       <= '0;
      depth_q      <= '0;
      complete_q   <= 1'b0;
      top_node_q   <= '0;
      top_right_q  <= 1'b0;
      root_leaf_q  <= 1'b0;
      cur_idx_q    <= '0;
      cur_right_q  <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      expected_q   <= expected_d;
      done_q       <= done_d;
      used_q       <= used_d;
      depth_q      <= depth_d;
      complete_q   <= complete_d;
      top_node_q   <= top_node_d;
      top_right_q  <= top_right_d;
      root_leaf_q  <= root_leaf_d;
      cur_idx_q    <= cur_idx_d;
      cur_right_q  <= cur_right_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // payload flops
  always_ff @(posedge clk_i) begin
    root_sym_q   <= root_sym_d;
    root_right_q <= root_right_d;
    pend_addr_q  <= pend_addr_d;
    pend_right_q <= pend_right_d;
    if (in_acc) begin
      kind_q <= kind_i;
      sym_q  <= leaf_symbol_i;
      nxt_q  <= node_raddr;
      fwd_q  <= pend_valid_q && (pend_addr_q == node_raddr);
    end
  end

  // node store
  hsd_ram #(
    .WIDTH (EW),
    .DEPTH (NODE_SLOTS)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (in_acc),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  // open-node stack, top entry held in flops
  hsd_ram #(
    .WIDTH (TW),
    .DEPTH (STACK_SLOTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (in_acc),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // result queue
  hsd_out_buffer u_out_buffer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign symbol_o      = out_data.symbol;
  assign last_symbol_o = out_data.last_symbol;
  assign error_o       = out_data.error;

endmodule

### sv/hsd_checker.sv
// ----------------------------------------------------------------------------
// hsd_checker
// Port-level checks of the huffman stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hsd_checker
  import hsd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [SymW-1:0]   symbol_o,
  input logic              last_symbol_o,
  input logic [1:0]        error_o,
  input logic              cfg_ready_o
);

  // an accepted request keeps the input closed while it executes
  a_two_cycle_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken in the cycle after an accept");

  // register port closed while an item is in flight
  a_cfg_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !cfg_ready_o)
    else $error("register port open during an item");

  // error results carry no symbol and no last flag
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_o != ERR_NONE) |-> (symbol_o == '0) && !last_symbol_o)
    else $error("error result with symbol or last flag");

  // no unused error code
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (error_o != 2'd3))
    else $error("unknown error code");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(symbol_o)
      && $stable(last_symbol_o) && $stable(error_o))
    else $error("stalled result changed");

endmodule

bind huffman_stream_decoder hsd_checker u_hsd_checker (.*);

### verif/tb_huffman_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_stream_decoder
// Self-checking bench for the huffman stream decoder. A directed table covers
// reset, rejected tokens, the count register extremes and a leaf root. A long
// phase then pushes the open-node stack and the node store to their limits,
// and a right spine is walked mostly to its bottom. Random phases follow,
// each building a random preorder tree and decoding random code bits. Every
// input request is mirrored in a local tree walker whose results are queued
// and compared with the output in order.
// ----------------------------------------------------------------------------
module tb_huffman_stream_decoder;
  import hsd_pkg::*;

  localparam int unsigned NodeIdxW     = $clog2(HsdNodeSlots);
  localparam int unsigned StackIdxW    = $clog2(HsdStackSlots);
  localparam logic [1:0]  KindSpare    = 2'd3;
  localparam int          SettleCycles = 16;
  localparam int          RandomItems  = 40;
  localparam int          SpineLevels  = 12;
  localparam int          SpineBits    = 30;
  localparam int          ReportLimit  = 10;
  localparam longint      RunLimitNs   = 2_000_000;

  // one node and one open-stack entry of the local tree walker
  typedef struct packed {
    logic                is_leaf;
    logic [SymW-1:0]     sym;
    logic [NodeIdxW-1:0] left;
    logic [NodeIdxW-1:0] right;
  } tree_node_t;

  typedef struct packed {
    logic [NodeIdxW-1:0] node;
    logic                right_next;
  } open_slot_t;

  // one row of the directed table
  typedef struct {
    bit                is_count;
    logic [CountW-1:0] count;
    logic [1:0]        kind;
    logic [SymW-1:0]   sym;
    logic              cb;
    bit                known;
    result_t           res;
  } plan_row_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [1:0]        kind_i        = KIND_INTERNAL;
  logic [SymW-1:0]   leaf_symbol_i = '0;
  logic              code_bit_i    = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [SymW-1:0]   symbol_o;
  logic              last_symbol_o;
  logic [1:0]        error_o;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_data_i    = '0;

  // local tree walker state
  tree_node_t          walk_nodes [HsdNodeSlots];
  open_slot_t          walk_open  [HsdStackSlots];
  logic [8:0]          open_depth;
  logic [9:0]          nodes_built;
  logic [NodeIdxW-1:0] walk_at;
  logic                tree_ready;
  logic [CountW-1:0]   symbols_out;
  logic [CountW-1:0]   symbols_goal;

  result_t   symbols_due [$];
  plan_row_t plan [$];
  bit        calm_mode     = 1'b0;
  int        applied_items = 0;
  int        mismatch_count = 0;
  int        stall_left    = 0;
  int        random_start;
  result_t   seen_res;
  result_t   want_res;

  huffman_stream_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .leaf_symbol_i (leaf_symbol_i),
    .code_bit_i    (code_bit_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .symbol_o      (symbol_o),
    .last_symbol_o (last_symbol_o),
    .error_o       (error_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RunLimitNs);
    $display("huffman_stream_decoder test failed");
    $finish;
  end

  // random payload pieces
  function automatic logic [SymW-1:0] rand_sym();
    return SymW'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom);
  endfunction

  // tree, stack, walk and symbol count back to empty
  function automatic void clear_walker();
    open_depth  = '0;
    nodes_built = '0;
    walk_at     = '0;
    tree_ready  = 1'b0;
    symbols_out = '0;
  endfunction

  // one input request through the tree walker; returns 1 when a result is due
  function automatic bit tree_decode(input logic [1:0] kind, input logic [SymW-1:0] sym,
                                     input logic cb, output result_t res,
                                     output bit ignored);
    logic [8:0]           depth_after;
    logic                 attach_right;
    logic                 is_leaf;
    logic [NodeIdxW-1:0]  idx;
    logic [NodeIdxW-1:0]  parent;
    logic [NodeIdxW-1:0]  next_at;
    logic [StackIdxW-1:0] top_slot;
    res      = '{symbol: '0, last_symbol: 1'b0, error: ERR_NONE};
    ignored  = 1'b0;
    top_slot = StackIdxW'(open_depth - 9'd1);
    case (kind)
      KIND_INTERNAL, KIND_LEAF: begin
        is_leaf = (kind == KIND_LEAF);
        if (tree_ready || nodes_built >= HsdNodeSlots) begin
          res.error = ERR_REJECT;
          return 1'b1;
        end
        // a right attach pops the parent before any push
        depth_after  = open_depth;
        attach_right = 1'b0;
        if (nodes_built != 0 && open_depth != 0) begin
          attach_right = walk_open[top_slot].right_next;
          if (attach_right) depth_after = depth_after - 9'd1;
        end
        if (!is_leaf && depth_after >= HsdStackSlots) begin
          res.error = ERR_REJECT;
          return 1'b1;
        end
        idx = nodes_built[NodeIdxW-1:0];
        walk_nodes[idx] = '{is_leaf: is_leaf, sym: is_leaf ? sym : '0, left: '0, right: '0};
        if (nodes_built != 0 && open_depth != 0) begin
          parent = walk_open[top_slot].node;
          if (attach_right) begin
            walk_nodes[parent].right = idx;
            open_depth = open_depth - 9'd1;
          end else begin
            walk_nodes[parent].left = idx;
            walk_open[top_slot].right_next = 1'b1;
          end
        end
        nodes_built = nodes_built + 10'd1;
        if (!is_leaf) begin
          walk_open[open_depth[StackIdxW-1:0]] = '{node: idx, right_next: 1'b0};
          open_depth = open_depth + 9'd1;
        end
        if (open_depth == 0) tree_ready = 1'b1;
        return 1'b0;
      end
      KIND_CODE: begin
        if (!tree_ready) begin
          res.error = ERR_NO_TREE;
          return 1'b1;
        end
        if (symbols_out == symbols_goal) begin
          ignored = 1'b1;
          return 1'b0;
        end
        // a leaf root answers every bit
        if (walk_nodes[0].is_leaf) next_at = '0;
        else next_at = cb ? walk_nodes[walk_at].right : walk_nodes[walk_at].left;
        if (!walk_nodes[next_at].is_leaf) begin
          walk_at = next_at;
          return 1'b0;
        end
        walk_at           = '0;
        symbols_out       = symbols_out + 1;
        res.symbol        = walk_nodes[next_at].sym;
        res.last_symbol   = (symbols_out == symbols_goal);
        return 1'b1;
      end
      default: begin
        ignored = 1'b1;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic plan_row_t row_count(input logic [CountW-1:0] value);
    plan_row_t row;
    row          = '{default: '0};
    row.is_count = 1'b1;
    row.count    = value;
    return row;
  endfunction

  function automatic plan_row_t row_item(input logic [1:0] kind, input logic [SymW-1:0] sym,
                                         input logic cb);
    plan_row_t row;
    row      = '{default: '0};
    row.kind = kind;
    row.sym  = sym;
    row.cb   = cb;
    return row;
  endfunction

  function automatic plan_row_t row_known(input logic [1:0] kind, input logic [SymW-1:0] sym,
                                          input logic cb, input logic [SymW-1:0] rsym,
                                          input logic rlast, input err_e rerr);
    plan_row_t row;
    row       = row_item(kind, sym, cb);
    row.known = 1'b1;
    row.res   = '{symbol: rsym, last_symbol: rlast, error: rerr};
    return row;
  endfunction

  function automatic void note_mismatch(input string what, input result_t want,
                                        input result_t got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit)
      $display("%0t: %s: expected sym %02h last %0d err %0d, got sym %02h last %0d err %0d",
               $time, what, want.symbol, want.last_symbol, want.error,
               got.symbol, got.last_symbol, got.error);
  endfunction

  // send one input request; a known result overrides the walker's
  task automatic send_item(input logic [1:0] kind, input logic [SymW-1:0] sym,
                           input logic cb, input bit known, input result_t known_res);
    int      gap;
    result_t res;
    bit      has_res;
    bit      ignored;
    gap = calm_mode ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    leaf_symbol_i <= sym;
    code_bit_i    <= cb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    has_res = tree_decode(kind, sym, cb, res, ignored);
    if (known) symbols_due.push_back(known_res);
    else if (has_res) symbols_due.push_back(res);
    if (!ignored) applied_items++;
  endtask

  // hold off until every due result has come, then let the block go quiet
  task automatic settle_results();
    in_valid_i <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write the symbol count register while idle
  task automatic write_count(input logic [CountW-1:0] value);
    settle_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i  <= 1'b0;
    symbols_goal = value;
    clear_walker();
  endtask

  // random tree in preorder, with stray and broken requests, then code bits
  task automatic run_random_phase(input bit force_pause);
    logic [CountW-1:0] goal;
    int                pick;
    int                need;
    int                branch_cnt;
    int                branch_cap;
    int                bits;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       goal = '0;
      1:       goal = '1;
      2:       goal = $urandom;
      3:       goal = 32'd1;
      default: goal = $urandom_range(1, 24);
    endcase
    write_count(goal);
    calm_mode = ($urandom_range(0, 3) == 0);
    // code bit before any tree
    if ($urandom_range(0, 4) == 0) send_item(KIND_CODE, rand_sym(), rand_bit(), 1'b0, '0);
    branch_cap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
    need       = 1;
    branch_cnt = 0;
    while (need > 0) begin
      if ($urandom_range(0, 29) == 0)
        send_item(2'($urandom_range(0, 3)), rand_sym(), rand_bit(), 1'b0, '0);
      if (branch_cnt < branch_cap && $urandom_range(0, 1) == 1) begin
        send_item(KIND_INTERNAL, rand_sym(), rand_bit(), 1'b0, '0);
        branch_cnt++;
        need++;
      end else begin
        send_item(KIND_LEAF, rand_sym(), rand_bit(), 1'b0, '0);
        need--;
      end
    end
    // token after the tree is done
    if ($urandom_range(0, 4) == 0)
      send_item(2'($urandom_range(0, 1)), rand_sym(), rand_bit(), 1'b0, '0);
    if (force_pause || $urandom_range(0, 3) == 0) settle_results();
    bits = $urandom_range(4, 60);
    repeat (bits) begin
      if ($urandom_range(0, 39) == 0) settle_results();
      if ($urandom_range(0, 24) == 0) send_item(KindSpare, rand_sym(), rand_bit(), 1'b0, '0);
      send_item(KIND_CODE, rand_sym(), rand_bit(), 1'b0, '0);
    end
  endtask

  // result side: random stall per request, in-order compare
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_res = '{symbol: symbol_o, last_symbol: last_symbol_o, error: err_e'(error_o)};
      if (symbols_due.size() == 0) begin
        note_mismatch("result with none due", '0, seen_res);
      end else begin
        want_res = symbols_due.pop_front();
        if (seen_res != want_res) note_mismatch("result mismatch", want_res, seen_res);
      end
      stall_left = calm_mode ? 0 : $urandom_range(0, 5);
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  // main sequence
  initial begin
    symbols_goal = '0;
    clear_walker();

    // directed table
    plan.push_back(row_known(KIND_CODE, 8'h00, 1'b0, 8'h00, 1'b0, ERR_NO_TREE));
    plan.push_back(row_count(32'd3));
    plan.push_back(row_known(KIND_CODE, 8'hFF, 1'b1, 8'h00, 1'b0, ERR_NO_TREE));
    plan.push_back(row_item(KIND_INTERNAL, 8'hFF, 1'b1));
    plan.push_back(row_item(KIND_LEAF, 8'h00, 1'b0));
    plan.push_back(row_item(KIND_INTERNAL, 8'h00, 1'b0));
    plan.push_back(row_item(KIND_LEAF, 8'hFF, 1'b1));
    plan.push_back(row_item(KIND_LEAF, 8'hA5, 1'b0));
    plan.push_back(row_known(KIND_CODE, 8'h00, 1'b0, 8'h00, 1'b0, ERR_NONE));
    plan.push_back(row_item(KIND_CODE, 8'h00, 1'b1));
    plan.push_back(row_known(KIND_CODE, 8'h00, 1'b0, 8'hFF, 1'b0, ERR_NONE));
    plan.push_back(row_item(KIND_CODE, 8'h00, 1'b1));
    plan.push_back(row_known(KIND_CODE, 8'h00, 1'b1, 8'hA5, 1'b1, ERR_NONE));
    plan.push_back(row_item(KIND_CODE, 8'hFF, 1'b0));
    plan.push_back(row_known(KIND_LEAF, 8'h3C, 1'b0, 8'h00, 1'b0, ERR_REJECT));
    plan.push_back(row_known(KIND_INTERNAL, 8'h00, 1'b0, 8'h00, 1'b0, ERR_REJECT));
    plan.push_back(row_item(KindSpare, 8'hFF, 1'b1));
    plan.push_back(row_count(32'hFFFF_FFFF));
    plan.push_back(row_item(KIND_LEAF, 8'h5A, 1'b0));
    plan.push_back(row_known(KIND_CODE, 8'h00, 1'b0, 8'h5A, 1'b0, ERR_NONE));
    plan.push_back(row_known(KIND_CODE, 8'h00, 1'b1, 8'h5A, 1'b0, ERR_NONE));
    plan.push_back(row_count(32'd0));
    plan.push_back(row_known(KIND_CODE, 8'h00, 1'b1, 8'h00, 1'b0, ERR_NO_TREE));
    plan.push_back(row_item(KIND_INTERNAL, 8'h00, 1'b0));
    plan.push_back(row_item(KIND_LEAF, 8'h01, 1'b0));
    plan.push_back(row_item(KIND_LEAF, 8'h80, 1'b0));
    plan.push_back(row_item(KIND_CODE, 8'h00, 1'b1));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_count) write_count(plan[i].count);
      else send_item(plan[i].kind, plan[i].sym, plan[i].cb, plan[i].known, plan[i].res);
    end

    // deep left chain: full stack, one push too many, then fill the node store
    write_count(32'd5);
    repeat (HsdStackSlots + 1) send_item(KIND_INTERNAL, rand_sym(), rand_bit(), 1'b0, '0);
    repeat (HsdNodeSlots - HsdStackSlots) send_item(KIND_LEAF, rand_sym(), rand_bit(), 1'b0, '0);
    send_item(KIND_LEAF, rand_sym(), rand_bit(), 1'b0, '0);
    send_item(KIND_INTERNAL, rand_sym(), rand_bit(), 1'b0, '0);
    send_item(KIND_CODE, rand_sym(), rand_bit(), 1'b0, '0);

    // long right spine, walked mostly to the bottom
    write_count($urandom_range(10, 30));
    send_item(KIND_INTERNAL, rand_sym(), rand_bit(), 1'b0, '0);
    repeat (SpineLevels) begin
      send_item(KIND_LEAF, rand_sym(), rand_bit(), 1'b0, '0);
      send_item(KIND_INTERNAL, rand_sym(), rand_bit(), 1'b0, '0);
    end
    send_item(KIND_LEAF, rand_sym(), rand_bit(), 1'b0, '0);
    send_item(KIND_LEAF, rand_sym(), rand_bit(), 1'b0, '0);
    repeat (SpineBits) send_item(KIND_CODE, rand_sym(), ($urandom_range(0, 31) != 0), 1'b0, '0);

    // random phases
    random_start = applied_items;
    run_random_phase(1'b1);
    while (applied_items - random_start < RandomItems) run_random_phase(1'b0);

    settle_results();
    if (mismatch_count == 0 && symbols_due.size() == 0) begin
      $display("huffman_stream_decoder test passed");
    end else begin
      $display("huffman_stream_decoder test failed");
    end
    $finish;
  end

endmodule
